// File: sv/prl_pkg.sv
// shared types and constants for the per-second packet rate limiter
// no dependencies; imported by every module of the block
package prl_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 2;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned NUM_KINDS       = 4;

  // packet kinds
  localparam logic [1:0] OP_TCP_SEND = 2'd0;
  localparam logic [1:0] OP_TCP_RECV = 2'd1;
  localparam logic [1:0] OP_UDP_SEND = 2'd2;
  localparam logic [1:0] OP_UDP_RECV = 2'd3;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] packet_size;
    logic [31:0] seconds_now;
  } in_t;

  typedef struct packed {
    logic        drop;
    logic [31:0] kind_total;
    logic [31:0] average_segment;
  } out_t;

  // classified event handed from front to back
  typedef struct packed {
    logic        drop;
    logic [31:0] kind_total;
    logic        need_div;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } job_t;

endpackage

// File: sv/prl_fifo.sv
// small register-based job queue between the front and the back part
// depends on prl_pkg (job_t)
module prl_fifo
  import prl_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  job_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: sv/prl_front.sv
// front part: limit registers, window and counters, drop decision, byte total
// depends on prl_pkg (in_t, job_t, opcodes)
module prl_front
  import prl_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_t                  in_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]          cfg_data_i,
  input  logic                 q_full_i,
  output logic                 push_o,
  output job_t                 job_o
);

  logic [31:0] lim_q [NUM_KINDS];
  logic [31:0] tot_q [NUM_KINDS];
  logic [31:0] cnt_q [NUM_KINDS];
  logic [31:0] win_q;
  logic [63:0] byte_q;

  logic [1:0]  kind;
  logic [31:0] tcp_next;
  logic        need_div;
  logic        restart;
  logic        drop;
  logic [63:0] byte_d;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;
  assign kind       = in_i.opcode;

  always_comb begin
    tcp_next = tot_q[0] + 32'd1;
    need_div = (kind == OP_TCP_SEND) && (tcp_next != '0) && (in_i.packet_size != '0);
    byte_d   = need_div ? byte_q + {48'd0, in_i.packet_size} : byte_q;
    restart  = in_i.seconds_now > win_q;
    drop     = !restart && (lim_q[kind] != '0) && (cnt_q[kind] >= lim_q[kind]);

    job_o.drop       = drop;
    job_o.kind_total = drop ? tot_q[kind] : tot_q[kind] + 32'd1;
    job_o.need_div   = need_div;
    job_o.dividend   = byte_d;
    job_o.divisor    = tcp_next;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_KINDS; i++) begin
        lim_q[i] <= '0;
        tot_q[i] <= '0;
        cnt_q[i] <= '0;
      end
      win_q  <= '0;
      byte_q <= '0;
    end else begin
      if (cfg_we_i) begin
        lim_q[cfg_idx_i] <= cfg_data_i;
      end
      if (push_o) begin
        byte_q <= byte_d;
        if (restart) begin
          // new window: clear all per-second counts, count this beat
          win_q <= in_i.seconds_now;
          for (int i = 0; i < NUM_KINDS; i++) begin
            cnt_q[i] <= (2'(i) == kind) ? 32'd1 : 32'd0;
          end
          tot_q[kind] <= tot_q[kind] + 32'd1;
        end else if (!drop) begin
          cnt_q[kind] <= cnt_q[kind] + 32'd1;
          tot_q[kind] <= tot_q[kind] + 32'd1;
        end
      end
    end
  end

endmodule

// File: sv/prl_back.sv
// back part: serial 64/32 divider for the average segment size, output register
// depends on prl_pkg (job_t, out_t)
module prl_back
  import prl_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic job_valid_i,
  input  job_t job_i,
  output logic pop_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_WB
  } state_e;

  state_e      state_q;
  logic        out_valid_q;
  out_t        out_q;
  logic [31:0] avg_q;
  logic        drop_q;
  logic [31:0] tot_q;
  logic [63:0] dq_q;      // dividend shifts out, quotient shifts in
  logic [31:0] rem_q;
  logic [31:0] div_q;
  logic [5:0]  step_q;

  logic        out_free;
  logic        load_out;
  out_t        out_d;
  logic [32:0] shifted;
  logic        qbit;
  logic [31:0] rem_d;

  assign out_free    = !out_valid_q || out_ready_i;
  assign pop_o       = (state_q == ST_IDLE) && job_valid_i && (job_i.need_div || out_free);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_comb begin
    shifted = {rem_q, dq_q[63]};
    qbit    = (shifted >= {1'b0, div_q});
    rem_d   = qbit ? 32'(shifted - {1'b0, div_q}) : shifted[31:0];
  end

  // result register loads from a plain job or from a finished division
  always_comb begin
    load_out = out_free && ((state_q == ST_WB) ||
                            ((state_q == ST_IDLE) && job_valid_i && !job_i.need_div));
    out_d.drop            = (state_q == ST_WB) ? drop_q : job_i.drop;
    out_d.kind_total      = (state_q == ST_WB) ? tot_q : job_i.kind_total;
    out_d.average_segment = avg_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      avg_q       <= '0;
      drop_q      <= 1'b0;
      tot_q       <= '0;
      dq_q        <= '0;
      rem_q       <= '0;
      div_q       <= '0;
      step_q      <= '0;
    end else begin
      if (load_out) begin
        out_q       <= out_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (job_valid_i && job_i.need_div) begin
            drop_q  <= job_i.drop;
            tot_q   <= job_i.kind_total;
            dq_q    <= job_i.dividend;
            div_q   <= job_i.divisor;
            rem_q   <= '0;
            step_q  <= '0;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_q  <= rem_d;
          dq_q   <= {dq_q[62:0], qbit};
          step_q <= step_q + 1'b1;
          if (step_q == '1) begin
            avg_q   <= {dq_q[30:0], qbit};
            state_q <= ST_WB;
          end
        end
        ST_WB: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: sv/per_second_packet_rate_limiter.sv
// Per-second packet rate limiter. Each input beat is one packet event; the front
// part decides drop and updates the window and counters in the cycle it accepts
// the beat, then queues the event. The back part returns one result per event, in
// order. A TCP-sent event with nonzero size refreshes the average segment size with
// a bit-serial 64-by-32 divider (load, 64 divide steps, write-back); any other
// event loads the output register. The front keeps accepting while the queue has
// room, so the queue depth sets how far the front may run ahead of a division in
// progress. Limits are for the user to write through the configuration port only
// while the block is idle; the block itself does not enforce this.
module per_second_packet_rate_limiter
  import prl_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_t                  in_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_t                 out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]          cfg_data_i
);

  logic push;
  logic pop;
  logic q_full;
  logic q_valid;
  job_t job_in;
  job_t job_out;

  prl_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (job_in)
  );

  prl_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (job_out)
  );

  prl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (job_out),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

// File: sv/prl_checker.sv
// port-level checks for the rate limiter, bound to the top level
// depends on prl_pkg (out_t, constants)
module prl_checker
  import prl_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_o,
  input logic cfg_we_i
);

  // queue, divider and output register together hold at most this many events
  localparam int unsigned CAP   = QUEUE_DEPTH + 2;
  localparam int unsigned OUT_W = $clog2(CAP + 2);

  logic             in_fire;
  logic             out_fire;
  logic [OUT_W-1:0] pend_q;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (in_fire && !out_fire) begin
      pend_q <= pend_q + 1'b1;
    end else if (out_fire && !in_fire) begin
      pend_q <= pend_q - 1'b1;
    end
  end

  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pend_q != '0))
    else $error("result shown with no event pending");

  a_pending_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= OUT_W'(CAP))
    else $error("more events pending than the block can hold");

  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("result withdrawn before it was taken");

  a_out_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(out_o))
    else $error("stalled result changed");

  a_cfg_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |-> (pend_q == '0))
    else $error("limit written while events are in flight");

endmodule

bind per_second_packet_rate_limiter prl_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_prl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_o       (out_o),
  .cfg_we_i    (cfg_we_i)
);
